/* hw/rtl/itar_pkg.sv */
// ----------------------------------------------------------------------------
// itar_pkg: shared types and constants
// Sizes, codes, controller state, command/status structs, digit encoding.
// ----------------------------------------------------------------------------
package itar_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_RADIX   = 32;

	localparam int RADIX_W   = 6;
	localparam int CH_W      = 7;
	localparam int DIGIT_W   = $clog2(MAX_RADIX);
	localparam int CMP_W     = RADIX_W + 1;
	localparam int STEP_BITS = 8;
	localparam int DIV_CYCLES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int QW        = DIV_CYCLES * STEP_BITS;
	localparam int DC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int CNT_W     = $clog2(VALUE_WIDTH + 1);
	localparam int AW        = $clog2(VALUE_WIDTH);

	localparam int RADIX_MIN = 2;
	localparam int RADIX_DEC = 10;
	localparam int CH_ZERO   = 48;
	localparam int CH_A      = 65;
	localparam int CH_MINUS  = 45;
	localparam int CH_NONE   = 0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} itar_state_t;

	typedef struct packed {
		logic load;
		logic emit_bad;
		logic div_init;
		logic div_step;
		logic store;
		logic wr_zero;
		logic emit_minus;
		logic rd;
	} itar_cmd_t;

	typedef struct packed {
		logic radix_ok;
		logic q_zero;
		logic cnt_full;
		logic cnt_zero;
		logic cnt_one;
		logic div_last;
		logic minus;
		logic rd_pend;
	} itar_sts_t;

	function automatic logic [CH_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CH_W-1:0] c;
		if (d >= DIGIT_W'(RADIX_DEC)) begin
			c = CH_W'(CH_A) + CH_W'(d) - CH_W'(RADIX_DEC);
		end else begin
			c = CH_W'(CH_ZERO) + CH_W'(d);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/itar_ram.sv */
// ----------------------------------------------------------------------------
// itar_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module itar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/itar_ctrl.sv */
// ----------------------------------------------------------------------------
// itar_ctrl: conversion sequencer
// Steps divide/store per digit, then sign and reversed digit readout.
// ----------------------------------------------------------------------------
module itar_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  itar_pkg::itar_sts_t sts,
	output itar_pkg::itar_cmd_t cmd
);
	import itar_pkg::*;

	itar_state_t state_q, state_d;
	logic        done;

	assign done = sts.q_zero || sts.cnt_full;
	assign busy = (state_q != ST_IDLE) || sts.rd_pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !sts.rd_pend && sts.radix_ok) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = done ? ST_SIGN : ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_d = ST_CHECK;
			end
			ST_SIGN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.cnt_one) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !sts.rd_pend) begin
					cmd.load     = sts.radix_ok;
					cmd.emit_bad = !sts.radix_ok;
				end
			end
			ST_CHECK: begin
				cmd.div_init = !done;
				cmd.wr_zero  = done && sts.cnt_zero;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.store    = sts.div_last;
			end
			ST_SIGN: begin
				cmd.emit_minus = sts.minus;
			end
			ST_EMIT: begin
				cmd.rd = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

/* hw/rtl/itar_dp.sv */
// ----------------------------------------------------------------------------
// itar_dp: conversion datapath
// Magnitude, 8-bit-per-cycle radix divider, digit store, output register.
// ----------------------------------------------------------------------------
module itar_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [itar_pkg::VALUE_WIDTH-1:0] value,
	input  logic [itar_pkg::RADIX_W-1:0]         radix,
	input  itar_pkg::itar_cmd_t                  cmd,
	output itar_pkg::itar_sts_t                  sts,
	output logic                                 strobe,
	output logic [itar_pkg::CH_W-1:0]            ch,
	output logic                                 last,
	output logic                                 bad_radix
);
	import itar_pkg::*;

	logic [VALUE_WIDTH-1:0] raw, mag;
	logic [QW-1:0]          quot_q, q_v;
	logic [RADIX_W-1:0]     radix_q;
	logic                   minus_q;
	logic [DIGIT_W-1:0]     rem_q, r_v;
	logic [CMP_W-1:0]       t;
	logic [DC_W-1:0]        div_cnt_q;
	logic [CNT_W-1:0]       cnt_q, cnt_m1;
	logic                   rd_s1, last_s1;
	logic                   strobe_q, last_q, bad_q;
	logic [CH_W-1:0]        ch_q;
	logic                   wr_en;
	logic [DIGIT_W-1:0]     wr_data, rd_data;

	assign raw    = value;
	assign mag    = raw[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - raw) : raw;
	assign cnt_m1 = cnt_q - CNT_W'(1);

	always_comb begin
		r_v = rem_q;
		q_v = quot_q;
		t   = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t   = (CMP_W'(r_v) << 1) | CMP_W'(q_v[QW-1]);
			q_v = q_v << 1;
			if (t >= CMP_W'(radix_q)) begin
				t      = t - CMP_W'(radix_q);
				q_v[0] = 1'b1;
			end
			r_v = t[DIGIT_W-1:0];
		end
	end

	assign sts.radix_ok = (radix >= RADIX_W'(RADIX_MIN)) && (radix <= RADIX_W'(MAX_RADIX));
	assign sts.q_zero   = (quot_q == '0);
	assign sts.cnt_full = (cnt_q == CNT_W'(VALUE_WIDTH));
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.cnt_one  = (cnt_q == CNT_W'(1));
	assign sts.div_last = (div_cnt_q == DC_W'(DIV_CYCLES - 1));
	assign sts.minus    = minus_q;
	assign sts.rd_pend  = rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.load) begin
				quot_q <= QW'(mag);
				cnt_q  <= '0;
			end else begin
				if (cmd.div_step) quot_q <= q_v;
				if (cmd.store || cmd.wr_zero) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (cmd.rd) begin
					cnt_q <= cnt_m1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= radix;
			minus_q <= raw[VALUE_WIDTH-1] && (radix == RADIX_W'(RADIX_DEC));
		end
		if (cmd.div_init) begin
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= r_v;
			div_cnt_q <= div_cnt_q + DC_W'(1);
		end
	end

	assign wr_en   = cmd.store || cmd.wr_zero;
	assign wr_data = cmd.wr_zero ? '0 : r_v;

	itar_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (VALUE_WIDTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (cnt_m1[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			rd_s1    <= cmd.rd;
			strobe_q <= rd_s1 || cmd.emit_minus || cmd.emit_bad;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= sts.cnt_one;
		priority if (rd_s1) begin
			ch_q   <= digit_char(rd_data);
			last_q <= last_s1;
			bad_q  <= 1'b0;
		end else if (cmd.emit_minus) begin
			ch_q   <= CH_W'(CH_MINUS);
			last_q <= 1'b0;
			bad_q  <= 1'b0;
		end else begin
			ch_q   <= CH_W'(CH_NONE);
			last_q <= 1'b1;
			bad_q  <= cmd.emit_bad;
		end
	end

	assign strobe    = strobe_q;
	assign ch        = ch_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

endmodule

/* hw/rtl/int_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// int_to_ascii_radix: signed integer to ASCII digits in radix 2..32
// Emits digits most significant first, '-' only for negative radix 10.
//
//   channel  | handshake             | fields
//   ---------+-----------------------+---------------------------
//   input    | start && !busy        | value[31:0] s, radix[5:0]
//   result   | strobe, one cycle     | ch[6:0], last, bad_radix
//
// n digits: busy from the transfer until the last digit is read from the store.
// Each digit takes a check and a divider pass (8 quotient bits per cycle),
// then each digit is read back from the digit store.
// Bad radix: one result the next cycle, no busy time.
// Reset clears controller state, quotient, digit count and output strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module int_to_ascii_radix (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [itar_pkg::VALUE_WIDTH-1:0] value,
	input  logic [itar_pkg::RADIX_W-1:0]            radix,
	output logic                                    strobe,
	output logic [itar_pkg::CH_W-1:0]               ch,
	output logic                                    last,
	output logic                                    bad_radix
);
	import itar_pkg::*;

	itar_cmd_t cmd;
	itar_sts_t sts;

	itar_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	itar_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.radix     (radix),
		.cmd       (cmd),
		.sts       (sts),
		.strobe    (strobe),
		.ch        (ch),
		.last      (last),
		.bad_radix (bad_radix)
	);

endmodule

/* hw/rtl/itar_checker.sv */
// ----------------------------------------------------------------------------
// itar_checker: port-level checks
// Bad-radix results, busy after a good transfer, busy coverage of pending characters.
// ----------------------------------------------------------------------------
module itar_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    start,
	input logic                                    busy,
	input logic [itar_pkg::RADIX_W-1:0]            radix,
	input logic                                    strobe,
	input logic [itar_pkg::CH_W-1:0]               ch,
	input logic                                    last,
	input logic                                    bad_radix
);
	import itar_pkg::*;

	logic radix_bad;
	assign radix_bad = (radix < RADIX_W'(RADIX_MIN)) || (radix > RADIX_W'(MAX_RADIX));

	a_bad_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && bad_radix |-> last && (ch == CH_W'(CH_NONE)))
		else $error("bad radix result malformed");

	a_bad_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && radix_bad |=> strobe && bad_radix && !busy)
		else $error("bad radix not reported next cycle");

	a_good_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !radix_bad |=> busy && !strobe)
		else $error("conversion transfer did not raise busy");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("busy low while characters pending");

endmodule

bind int_to_ascii_radix itar_checker u_chk (.*);
